/* hdl/period_capture_freq_meter_defines.svh */
// Assertion macros for the period capture frequency meter checker.
`ifndef PERIOD_CAPTURE_FREQ_METER_DEFINES_SVH
`define PERIOD_CAPTURE_FREQ_METER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PCFM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define PCFM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/pcfm_pkg.sv */
// Package with constants, codes and control types of the period capture frequency meter.
`timescale 1ns / 1ps
`default_nettype none

package pcfm_pkg;

   localparam int STAMP_BITS = 16;
   localparam int FIELD_W    = 16;
   localparam int STAMP_W    = (STAMP_BITS < FIELD_W) ? STAMP_BITS : FIELD_W;
   localparam int CONV_W     = 32;
   localparam int DIV_STEPS  = FIELD_W;
   localparam int STEP_CNT_W = $clog2(DIV_STEPS);

   localparam int REQ_USER_W = 2;
   localparam int REQ_DATA_W = 2 * FIELD_W;
   localparam int RSP_DATA_W = 3 * FIELD_W;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [FIELD_W-1:0] CAPTURED_FLAG = FIELD_W'(2);
   localparam logic [FIELD_W-1:0] FREQ_MAX      = '1;

   typedef enum logic [REQ_USER_W-1:0] {
      CMD_CAPTURE = 2'd0,
      CMD_SET     = 2'd1,
      CMD_CLEAR   = 2'd2,
      CMD_STATUS  = 2'd3
   } cmd_code_type;

   typedef enum logic [CSR_ADDR_W-3:0] {
      REG_CONV_FACTOR = 1'b0
   } csr_index_type;

   typedef struct packed {
      logic accept;
      logic setup;
      logic step;
      logic load_out;
   } pcfm_cmd_type;

   typedef struct packed {
      logic skip_div;
   } pcfm_status_type;

endpackage

`default_nettype wire

/* hdl/pcfm_ctrl.sv */
// Controller state machine: transfer handshakes, divider sequencing, output register valid.
`timescale 1ns / 1ps
`default_nettype none

module pcfm_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   input  wire pcfm_pkg::pcfm_status_type status,
   output pcfm_pkg::pcfm_cmd_type        cmd
);
   import pcfm_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SETUP,
      S_DIV,
      S_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = S_SETUP;
            end
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            cnt_in    = '0;
            state_in  = status.skip_div ? S_DONE : S_DIV;
         end
         S_DIV: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == STEP_CNT_W'(DIV_STEPS - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // output slot free, or emptied by a transfer this cycle
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = cmd.load_out | (rsp_valid_ff & ~rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

/* hdl/pcfm_dp.sv */
// Datapath: capture pairing, flag register, period register, radix-2 divider, result register.
`timescale 1ns / 1ps
`default_nettype none

module pcfm_dp (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire pcfm_pkg::pcfm_cmd_type              cmd,
   output pcfm_pkg::pcfm_status_type                status,
   input  wire logic [pcfm_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  wire logic [pcfm_pkg::REQ_USER_W-1:0]     req_tuser,
   input  wire logic [pcfm_pkg::CONV_W-1:0]         conv_factor,
   output logic      [pcfm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                     rsp_tuser
);
   import pcfm_pkg::*;

   logic                  pending_ff, pending_in;
   logic [STAMP_W-1:0]    first_ff, first_in;
   logic [FIELD_W-1:0]    period_ff, period_in;
   logic [FIELD_W-1:0]    flag_ff, flag_in;
   logic [FIELD_W-1:0]    rem_ff, rem_in;
   logic [FIELD_W-1:0]    quo_ff, quo_in;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;
   logic                  out_valid_ff, out_valid_in;

   logic [STAMP_W-1:0]    stamp;
   logic [FIELD_W-1:0]    mask;
   cmd_code_type          code;
   logic [FIELD_W-1:0]    conv_hi;
   logic [FIELD_W-1:0]    conv_lo;
   logic [FIELD_W:0]      trial;
   logic [FIELD_W:0]      diff;
   logic                  fits;
   logic                  period_zero;
   logic                  saturate;
   logic [FIELD_W-1:0]    freq;

   assign stamp   = req_tdata[STAMP_W-1:0];
   assign mask    = req_tdata[2*FIELD_W-1:FIELD_W];
   assign code    = cmd_code_type'(req_tuser);
   assign conv_hi = conv_factor[CONV_W-1:CONV_W-FIELD_W];
   assign conv_lo = conv_factor[FIELD_W-1:0];

   // quotient overflows 16 bits exactly when the upper dividend half reaches the divisor
   assign period_zero     = (period_ff == '0);
   assign saturate        = (conv_hi >= period_ff);
   assign status.skip_div = period_zero | saturate;

   // one restoring step: remainder stays below the divisor, so it fits in 16 bits
   assign trial = {rem_ff, quo_ff[FIELD_W-1]};
   assign diff  = trial - {1'b0, period_ff};
   assign fits  = (trial >= {1'b0, period_ff});

   always_comb begin
      pending_in = pending_ff;
      first_in   = first_ff;
      period_in  = period_ff;
      flag_in    = flag_ff;
      if (cmd.accept) begin
         case (code)
            CMD_CAPTURE: begin
               if (!pending_ff) begin
                  first_in   = stamp;
                  pending_in = 1'b1;
               end else begin
                  // zero or negative difference: timer wrapped, drop the pair
                  if (stamp > first_ff) begin
                     period_in = FIELD_W'(stamp - first_ff);
                     flag_in   = flag_ff | CAPTURED_FLAG;
                  end
                  pending_in = 1'b0;
               end
            end
            CMD_SET: begin
               flag_in = flag_ff | mask;
            end
            CMD_CLEAR: begin
               flag_in = flag_ff & ~mask;
            end
            CMD_STATUS: begin
               flag_in = flag_ff;
            end
            default: begin
               flag_in = flag_ff;
            end
         endcase
      end
   end

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (cmd.setup) begin
         rem_in = conv_hi;
         quo_in = conv_lo;
      end else if (cmd.step) begin
         rem_in = fits ? diff[FIELD_W-1:0] : trial[FIELD_W-1:0];
         quo_in = {quo_ff[FIELD_W-2:0], fits};
      end
   end

   always_comb begin
      if (period_zero) begin
         freq = '0;
      end else if (saturate) begin
         freq = FREQ_MAX;
      end else begin
         freq = quo_ff;
      end
      out_data_in  = out_data_ff;
      out_valid_in = out_valid_ff;
      if (cmd.load_out) begin
         out_data_in  = {freq, period_ff, flag_ff};
         out_valid_in = ~period_zero;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         first_ff   <= '0;
         period_ff  <= '0;
         flag_ff    <= '0;
      end else begin
         pending_ff <= pending_in;
         first_ff   <= first_in;
         period_ff  <= period_in;
         flag_ff    <= flag_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      out_data_ff  <= out_data_in;
      out_valid_ff <= out_valid_in;
   end

   assign rsp_tdata = out_data_ff;
   assign rsp_tuser = out_valid_ff;

endmodule

`default_nettype wire

/* hdl/period_capture_freq_meter.sv */
// Reciprocal frequency meter: input capture pairing, flag register and 32-by-16 divider.
//
// Usage:
//  req channel: one transfer per item. req_tuser carries the command (capture edge,
//  set flags, clear flags, status read); req_tdata carries the capture stamp and the
//  flag mask. Every item yields exactly one transfer on the rsp channel with the
//  flags, the stored period, the frequency (conv_factor / period, saturated to
//  65535) and, on rsp_tuser, a bit saying whether a period is stored.
//  csr port: APB-style, one register (conv_factor) at byte address 0; write it only
//  while no item is in flight.
//  Timing: one item at a time. With no period stored, or when the quotient would
//  saturate, the controller goes from setup straight to the done state and loads
//  the result register. Otherwise the 16-step radix-2 divider loop runs between
//  setup and done. A new item is taken only once the last result is loaded.
//  The result register frees the input side once loaded: req_tready rises while a
//  result still waits. If the receiver stalls, the next item completes and waits
//  in the controller until the result register empties.
//  Reset clears the pairing state, period, flags, conv_factor and the result valid.
`timescale 1ns / 1ps
`default_nettype none

module period_capture_freq_meter (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // req
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [pcfm_pkg::REQ_DATA_W-1:0]     req_tdata,  // stamp[15:0], flag_mask[31:16]
   input  wire logic [pcfm_pkg::REQ_USER_W-1:0]     req_tuser,  // cmd[1:0]
   // rsp
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic      [pcfm_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // flag_bits[15:0],
                                                                // period_counts[31:16],
                                                                // frequency[47:32]
   output logic                                     rsp_tuser,  // freq_valid
   // csr
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [pcfm_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [pcfm_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic      [pcfm_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                     csr_pready
);
   import pcfm_pkg::*;

   logic [CONV_W-1:0] conv_ff, conv_in;
   logic              csr_write;
   csr_index_type     csr_index;
   pcfm_cmd_type      cmd;
   pcfm_status_type   status;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      conv_in = conv_ff;
      if (csr_write && csr_index == REG_CONV_FACTOR) begin
         conv_in = csr_pwdata;
      end
      csr_prdata = (csr_index == REG_CONV_FACTOR) ? conv_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         conv_ff <= '0;
      end else begin
         conv_ff <= conv_in;
      end
   end

   pcfm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pcfm_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .conv_factor (conv_ff),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

`default_nettype wire

/* hdl/pcfm_checker.sv */
// Port-level checker for the period capture frequency meter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "period_capture_freq_meter_defines.svh"

module pcfm_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_tvalid,
   input wire logic                                req_tready,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [pcfm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input wire logic                                rsp_tuser
);
   import pcfm_pkg::*;

   logic [FIELD_W-1:0] period_f;
   logic [FIELD_W-1:0] freq_f;

   assign period_f = rsp_tdata[2*FIELD_W-1:FIELD_W];
   assign freq_f   = rsp_tdata[3*FIELD_W-1:2*FIELD_W];

   // stalled result must hold
   `PCFM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "rsp changed while stalled")

   // one item at a time: busy right after an input transfer
   `PCFM_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready,
      !req_tready, "req_tready high right after an input transfer")

   `PCFM_ASSERT_SAME(a_invalid_zero, clock, reset, rsp_tvalid && !rsp_tuser,
      period_f == '0 && freq_f == '0, "freq_valid low but period or frequency nonzero")

   `PCFM_ASSERT_SAME(a_valid_period, clock, reset, rsp_tvalid && rsp_tuser,
      period_f != '0, "freq_valid high with zero period")

endmodule

bind period_capture_freq_meter pcfm_checker u_checker (.*);

`default_nettype wire
